// ===== design/pcl_pkg.sv =====
// types and constants shared by the positional list controller and datapath
package pcl_pkg;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_DEL   = 2'd1,
    MODE_GET   = 2'd2,
    MODE_PRINT = 2'd3
  } pcl_mode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } pcl_status_t;

  typedef enum logic [2:0] {
    PTR_HOLD    = 3'd0,
    PTR_CNT_M1  = 3'd1,
    PTR_RANK    = 3'd2,
    PTR_RANK_M1 = 3'd3,
    PTR_ZERO    = 3'd4,
    PTR_INC     = 3'd5,
    PTR_DEC     = 3'd6
  } pcl_ptr_op_t;

  typedef enum logic [1:0] {
    WR_UP   = 2'd0,
    WR_DOWN = 2'd1,
    WR_ELEM = 2'd2
  } pcl_wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } pcl_cnt_op_t;

  typedef struct packed {
    logic        req_load;
    pcl_ptr_op_t ptr_op;
    logic        rd_en;
    logic        rd_ahead;
    logic        wr_en;
    pcl_wr_sel_t wr_sel;
    pcl_cnt_op_t cnt_op;
    logic        out_load;
    pcl_status_t out_status;
    logic        out_has;
    logic        out_last;
  } pcl_cmd_t;

  typedef struct packed {
    pcl_mode_t mode;
    logic      rank_ok;
    logic      add_rank_ok;
    logic      full;
    logic      empty;
    logic      append;
    logic      rank_is_cnt;
    logic      ptr_at_rank_m1;
    logic      ptr_at_cnt_m1;
  } pcl_flags_t;

endpackage

// ===== design/pcl_ram.sv =====
// generic single write port ram with registered read
module pcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/pcl_datapath.sv =====
// datapath: request latch, element count, pointer, element store and result register
module pcl_datapath
  import pcl_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pcl_cmd_t    cmd,
  output pcl_flags_t  flags,
  input  logic [1:0]  in_mode,
  input  logic [5:0]  in_rank,
  input  logic [7:0]  in_elem,
  output logic [1:0]  out_status,
  output logic        out_has_elem,
  output logic [7:0]  out_elem_out,
  output logic        out_last
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > 6) ? CW : 6) + 1;

  pcl_mode_t   mode_r;
  logic [5:0]  rank_r;
  logic [7:0]  elem_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [AW-1:0] rd_addr_q_r;
  pcl_status_t out_status_r;
  logic        out_has_r;
  logic [7:0]  out_elem_r;
  logic        out_last_r;

  logic [CMPW-1:0] rank_e, cnt_e, ptr_e;
  logic [5:0]      rank_m1;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [7:0]      wr_data, rdata;

  assign rank_e  = CMPW'(rank_r);
  assign cnt_e   = CMPW'(cnt_r);
  assign ptr_e   = CMPW'(ptr_r);
  assign rank_m1 = rank_r - 6'd1;

  assign flags.mode           = mode_r;
  assign flags.rank_ok        = (rank_r != 6'd0) && (rank_e <= cnt_e);
  assign flags.add_rank_ok    = (rank_r != 6'd0) && (rank_e <= cnt_e + CMPW'(1));
  assign flags.full           = (cnt_r == CW'(CAPACITY));
  assign flags.empty          = (cnt_r == '0);
  assign flags.append         = (rank_e == cnt_e + CMPW'(1));
  assign flags.rank_is_cnt    = (rank_e == cnt_e);
  assign flags.ptr_at_rank_m1 = (ptr_e + CMPW'(1) == rank_e);
  assign flags.ptr_at_cnt_m1  = (ptr_e + CMPW'(1) == cnt_e);

  // pointer and count updates
  always_comb begin
    ptr_nxt = ptr_r;
    unique case (cmd.ptr_op)
      PTR_HOLD:    ptr_nxt = ptr_r;
      PTR_CNT_M1:  ptr_nxt = AW'(cnt_r - CW'(1));
      PTR_RANK:    ptr_nxt = AW'(rank_r);
      PTR_RANK_M1: ptr_nxt = AW'(rank_m1);
      PTR_ZERO:    ptr_nxt = '0;
      PTR_INC:     ptr_nxt = ptr_r + AW'(1);
      PTR_DEC:     ptr_nxt = ptr_r - AW'(1);
      default:     ptr_nxt = ptr_r;
    endcase
    cnt_nxt = cnt_r;
    unique case (cmd.cnt_op)
      CNT_HOLD: cnt_nxt = cnt_r;
      CNT_INC:  cnt_nxt = cnt_r + CW'(1);
      CNT_DEC:  cnt_nxt = cnt_r - CW'(1);
      default:  cnt_nxt = cnt_r;
    endcase
  end

  // store addressing
  always_comb begin
    rd_addr = cmd.rd_ahead ? (ptr_r + AW'(1)) : ptr_r;
    wr_addr = rd_addr_q_r + AW'(1);
    wr_data = rdata;
    unique case (cmd.wr_sel)
      WR_UP:   wr_addr = rd_addr_q_r + AW'(1);
      WR_DOWN: wr_addr = rd_addr_q_r - AW'(1);
      WR_ELEM: begin
        wr_addr = AW'(rank_m1);
        wr_data = elem_r;
      end
      default: wr_addr = rd_addr_q_r + AW'(1);
    endcase
  end

  pcl_ram #(
    .WIDTH (8),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.req_load) begin
      mode_r <= pcl_mode_t'(in_mode);
      rank_r <= in_rank;
      elem_r <= in_elem;
    end
    if (cmd.rd_en) begin
      rd_addr_q_r <= rd_addr;
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_has_r    <= cmd.out_has;
      out_elem_r   <= cmd.out_has ? rdata : 8'd0;
      out_last_r   <= cmd.out_last;
    end
  end

  assign out_status   = out_status_r;
  assign out_has_elem = out_has_r;
  assign out_elem_out = out_elem_r;
  assign out_last     = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_no_grow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cnt_op == CNT_INC) |-> !flags.full)
    else $error("count increment on full store");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && cmd.rd_en) |-> (wr_addr != rd_addr))
    else $error("store read and write at one address");

endmodule

// ===== design/pcl_ctrl.sv =====
// controller: request sequencing, shift loops, print walk and result handshake
module pcl_ctrl
  import pcl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  pcl_flags_t flags,
  output pcl_cmd_t   cmd
);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_DECODE    = 12'b0000_0000_0010,
    S_RESP      = 12'b0000_0000_0100,
    S_UP        = 12'b0000_0000_1000,
    S_UP_LAST   = 12'b0000_0001_0000,
    S_INS       = 12'b0000_0010_0000,
    S_DOWN      = 12'b0000_0100_0000,
    S_DOWN_LAST = 12'b0000_1000_0000,
    S_GET_RD    = 12'b0001_0000_0000,
    S_GET_OUT   = 12'b0010_0000_0000,
    S_PRINT_RD  = 12'b0100_0000_0000,
    S_PRINT_OUT = 12'b1000_0000_0000
  } pcl_state_t;

  pcl_state_t  state_r, state_nxt;
  logic        pend_r, pend_nxt;
  pcl_status_t resp_st_r, resp_st_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd            = '0;
    cmd.ptr_op     = PTR_HOLD;
    cmd.wr_sel     = WR_UP;
    cmd.cnt_op     = CNT_HOLD;
    cmd.out_status = ST_OK;
    state_nxt      = state_r;
    pend_nxt       = pend_r;
    resp_st_nxt    = resp_st_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        pend_nxt    = 1'b0;
        resp_st_nxt = ST_OK;
        unique case (flags.mode)
          MODE_ADD: begin
            if (!flags.add_rank_ok) begin
              resp_st_nxt = ST_BADPOS;
              state_nxt   = S_RESP;
            end else if (flags.full) begin
              resp_st_nxt = ST_FULL;
              state_nxt   = S_RESP;
            end else if (flags.append) begin
              state_nxt = S_INS;
            end else begin
              cmd.ptr_op = PTR_CNT_M1;
              state_nxt  = S_UP;
            end
          end
          MODE_DEL: begin
            if (!flags.rank_ok) begin
              resp_st_nxt = ST_BADPOS;
              state_nxt   = S_RESP;
            end else if (flags.rank_is_cnt) begin
              cmd.cnt_op = CNT_DEC;
              state_nxt  = S_RESP;
            end else begin
              cmd.ptr_op = PTR_RANK;
              state_nxt  = S_DOWN;
            end
          end
          MODE_GET: begin
            if (!flags.rank_ok) begin
              resp_st_nxt = ST_BADPOS;
              state_nxt   = S_RESP;
            end else begin
              cmd.ptr_op = PTR_RANK_M1;
              state_nxt  = S_GET_RD;
            end
          end
          MODE_PRINT: begin
            if (flags.empty) begin
              state_nxt = S_RESP;
            end else begin
              cmd.ptr_op = PTR_ZERO;
              state_nxt  = S_PRINT_RD;
            end
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_RESP: begin
        if (slot_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = resp_st_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      // read one below, write the previous read one above
      S_UP: begin
        cmd.rd_en  = 1'b1;
        cmd.wr_en  = pend_r;
        cmd.wr_sel = WR_UP;
        pend_nxt   = 1'b1;
        if (flags.ptr_at_rank_m1) begin
          state_nxt = S_UP_LAST;
        end else begin
          cmd.ptr_op = PTR_DEC;
        end
      end
      S_UP_LAST: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_UP;
        pend_nxt   = 1'b0;
        state_nxt  = S_INS;
      end
      S_INS: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_ELEM;
        cmd.cnt_op  = CNT_INC;
        resp_st_nxt = ST_OK;
        state_nxt   = S_RESP;
      end
      S_DOWN: begin
        cmd.rd_en  = 1'b1;
        cmd.wr_en  = pend_r;
        cmd.wr_sel = WR_DOWN;
        pend_nxt   = 1'b1;
        if (flags.ptr_at_cnt_m1) begin
          state_nxt = S_DOWN_LAST;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      S_DOWN_LAST: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_DOWN;
        cmd.cnt_op  = CNT_DEC;
        pend_nxt    = 1'b0;
        resp_st_nxt = ST_OK;
        state_nxt   = S_RESP;
      end
      S_GET_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_GET_OUT;
      end
      S_GET_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_has  = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_PRINT_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_PRINT_OUT;
      end
      // one beat per cycle while the result slot is free, next element read while this one loads
      S_PRINT_OUT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          cmd.out_has  = 1'b1;
          cmd.out_last = flags.ptr_at_cnt_m1;
          if (flags.ptr_at_cnt_m1) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.ptr_op   = PTR_INC;
            cmd.rd_en    = 1'b1;
            cmd.rd_ahead = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      resp_st_r   <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      resp_st_r   <= resp_st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result beat overwritten before taken");

  a_print_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.out_last) |=> (state_r == S_IDLE))
    else $error("request not closed after last beat");

endmodule

// ===== design/positional_char_list.sv =====
// top level of the positional byte list: ranked add, delete, get and print
//
// usage:
//   input channel in_valid/in_ready carries one request per beat: in_mode
//   (add, delete, get, print), a 1-based in_rank and the byte in_elem.
//   result channel out_valid/out_ready carries out_status, out_has_elem,
//   out_elem_out and out_last; out_last marks the final beat of a request.
//   add, delete and get give one beat; print gives one beat per element,
//   or a single empty beat when the list holds nothing.
// sequencing (n = elements held, r = rank):
//   rejected requests are answered from decode; get reads the store and
//   then loads the result; add moves n-r+1 elements at one per cycle
//   through the store's single write port, then writes the new byte;
//   delete moves n-r elements, none for the last element;
//   print streams one element per cycle while the receiver keeps up.
//   one request is in flight at a time; in_ready is high only when idle.
// reset: synchronous active low rst_n empties the list; store contents are
//   not cleared. a stalled receiver holds the result register and the
//   block waits with it; a finished result may wait while the next
//   request is accepted.
module positional_char_list
  import pcl_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [5:0] in_rank,
  input  logic [7:0] in_elem,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic       out_has_elem,
  output logic [7:0] out_elem_out,
  output logic       out_last
);

  pcl_cmd_t   cmd;
  pcl_flags_t flags;

  pcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .flags     (flags),
    .cmd       (cmd)
  );

  pcl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .flags        (flags),
    .in_mode      (in_mode),
    .in_rank      (in_rank),
    .in_elem      (in_elem),
    .out_status   (out_status),
    .out_has_elem (out_has_elem),
    .out_elem_out (out_elem_out),
    .out_last     (out_last)
  );

endmodule
